// File: hw/rtl/seven_segment_clock_pixel_mask_assert.svh
// Assertion macros for the seven-segment clock pixel mask.
`ifndef SEVEN_SEGMENT_CLOCK_PIXEL_MASK_ASSERT_SVH
`define SEVEN_SEGMENT_CLOCK_PIXEL_MASK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SSCPM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SSCPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sscpm_pkg.sv
// Package: types, field widths, register indexes and digit tables of the clock pixel mask.
package sscpm_pkg;

   // Field widths
   localparam int HOUR_W       = 5;
   localparam int MINUTE_W     = 6;
   localparam int SECOND_W     = 6;
   localparam int RUN_START_W  = 16;
   localparam int RUN_LENGTH_W = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 21;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MODE_FLAGS  = 3'd0,
      REG_SEG_PIXELS  = 3'd1,
      REG_COL_PIXELS  = 3'd2,
      REG_FIRST_PIXEL = 3'd3,
      REG_SEGMENT_MAP = 3'd4,
      REG_STRIP_LEN   = 3'd5
   } csr_index_type;

   // Mode flag bit positions
   localparam int MODE_ENABLE     = 0;
   localparam int MODE_SIX        = 1;
   localparam int MODE_TWELVE     = 2;
   localparam int MODE_HIDE_HOUR  = 3;
   localparam int MODE_HIDE_MIN   = 4;
   localparam int MODE_RTL        = 5;
   localparam int MODE_SHOW_COLON = 6;
   localparam int MODE_BLINK      = 7;

   // Reset values of the registers
   localparam logic [7:0]  MODE_RESET  = 8'd237;
   localparam logic [7:0]  SEG_PIX_RST = 8'd2;
   localparam logic [7:0]  COL_PIX_RST = 8'd2;
   localparam logic [15:0] FIRST_RST   = 16'd0;
   localparam logic [20:0] MAP_RESET   = 21'd1690122;
   localparam logic [15:0] STRIP_RST   = 16'd0;

   // Segment slots: a..g in a digit row; in the colon row colon 1, colon 2, then the close slot
   localparam logic [2:0] SEG_LAST   = 3'd6;
   localparam logic [2:0] SEG_COLON1 = 3'd0;
   localparam logic [2:0] SEG_COLON2 = 3'd1;
   localparam logic [2:0] SEG_FLUSH  = 3'd2;

   // Blocks from the clock start to each colon, in segment widths
   localparam logic [5:0] COLON1_BLOCKS = 6'd14;
   localparam logic [5:0] COLON2_BLOCKS = 6'd28;

   // Segment patterns, a in bit 6 down to g in bit 0
   localparam logic [6:0] SEG_PATTERNS [10] = '{
      7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
   };

   // One blanking run
   typedef struct packed {
      logic [RUN_START_W-1:0]  start;
      logic [RUN_LENGTH_W-1:0] length;
   } run_type;

   // Tens in [7:4] and ones in [3:0] of a value below 64
   function automatic logic [7:0] split_decimal(input logic [5:0] v);
      logic [3:0] t;
      logic [5:0] r;
      t = '0;
      for (int k = 6; k >= 1; k--) begin
         if (t == '0 && v >= 6'(10 * k)) begin
            t = 4'(k);
         end
      end
      r = v - 6'(6'(t) * 6'd10);
      return {t, r[3:0]};
   endfunction

endpackage

// File: hw/rtl/sscpm_if.sv
// Channel interfaces: time sample requests and blanking run responses.
interface sscpm_req_if import sscpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HOUR_W-1:0]   hour_value;
   logic [MINUTE_W-1:0] minute_value;
   logic [SECOND_W-1:0] second_value;

   modport source (output valid, hour_value, minute_value, second_value, input ready);
   modport sink   (input valid, hour_value, minute_value, second_value, output ready);
endinterface

interface sscpm_rsp_if import sscpm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [RUN_START_W-1:0]  run_start;
   logic [RUN_LENGTH_W-1:0] run_length;
   logic                    run_last;

   modport source (output valid, run_start, run_length, run_last, input ready);
   modport sink   (input valid, run_start, run_length, run_last, output ready);
endinterface

// File: hw/rtl/seven_segment_clock_pixel_mask.sv
// Seven-segment clock pixel mask: turns a time sample into LED-strip blanking runs.
//
// Each time sample (hour, minute, second) is decoded into a dark-segment mask when it is
// taken into a one-entry input buffer. A slot scanner then walks one candidate run per
// cycle while the response channel does not stall: seven segments for each of MAX_DIGITS
// digits, colon 1, colon 2 and one closing slot, whatever the number of runs it yields;
// a stalled response channel holds the scan. The next sample is taken into the buffer
// while the current one is scanned and enters the scanner straight after the closing slot.
// A run passes from its slot through the candidate stage and a holding register into the
// response register: it waits in the holding register until the next run or the closing
// slot comes by, which lets the last run carry run_last.
// Configuration is written through the csr_ port and must only change while the block
// is idle. Disabled mode still costs the scan but emits nothing.
module seven_segment_clock_pixel_mask import sscpm_pkg::*; #(
   parameter int MAX_DIGITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   sscpm_req_if.sink              req_ch,
   sscpm_rsp_if.source            rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DigW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int PosW = $clog2(MAX_DIGITS + 1);
   localparam logic [PosW-1:0] ColonRow = PosW'(MAX_DIGITS);
   localparam logic SixAllowed = (MAX_DIGITS >= 6);

   // Configuration registers
   logic [7:0]  mode_ff,    mode_in;
   logic [7:0]  seg_pix_ff, seg_pix_in;
   logic [7:0]  col_pix_ff, col_pix_in;
   logic [15:0] first_ff,   first_in;
   logic [20:0] map_ff,     map_in;
   logic [15:0] strip_ff,   strip_in;

   // Input buffer
   logic       buf_valid_ff, buf_valid_in;
   logic [6:0] buf_dig_ff [MAX_DIGITS];
   logic [6:0] buf_dig_in [MAX_DIGITS];
   logic [1:0] buf_col_ff, buf_col_in;

   // Slot scanner
   logic            busy_ff, busy_in;
   logic [PosW-1:0] pos_ff,  pos_in;
   logic [2:0]      seg_ff,  seg_in;
   logic [6:0]      dig_dark_ff [MAX_DIGITS];
   logic [6:0]      dig_dark_in [MAX_DIGITS];
   logic [1:0]      col_dark_ff, col_dark_in;

   // Candidate run stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_flush_ff, s1_flush_in;
   logic [17:0] s1_start_ff, s1_start_in;
   logic [7:0]  s1_len_ff,   s1_len_in;

   // Pending run and response register
   logic    pend_valid_ff, pend_valid_in;
   run_type pend_run_ff,   pend_run_in;
   logic    out_valid_ff,  out_valid_in;
   run_type out_run_ff,    out_run_in;
   logic    out_last_ff,   out_last_in;

   // Shared combinational signals
   logic            six_en;
   logic [2:0]      ndig;
   logic [7:0]      sp_eff;
   logic [7:0]      cp_eff;
   logic            adv;
   logic            req_fire;
   logic            take;
   logic            in_colon;
   logic            at_flush;
   logic [DigW-1:0] dpos;
   logic [2:0]      phys;
   logic [2:0]      blk;
   logic [2:0]      map_blk [7];
   logic            slot_dark;
   logic [5:0]      mult;
   logic [1:0]      cmul;
   logic [13:0]     seg_off;
   logic [9:0]      col_off;
   logic [17:0]     strip_ext;
   logic [17:0]     room;
   logic            run_ok;
   logic [7:0]      clip_len;

   // Decode signals
   logic [HOUR_W-1:0] hour_fold;
   logic [7:0]        hour_dec;
   logic [7:0]        min_dec;
   logic [7:0]        sec_dec;
   logic [3:0]        dig_val [6];
   logic [5:0]        blank;
   logic              colon_dark;

   assign six_en = mode_ff[MODE_SIX] && SixAllowed;
   assign ndig   = six_en ? 3'd6 : 3'd4;
   assign sp_eff = (seg_pix_ff == '0) ? 8'd1 : seg_pix_ff;
   assign cp_eff = (col_pix_ff == '0) ? 8'd1 : col_pix_ff;

   // Handshakes
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !buf_valid_ff;
   assign req_fire     = req_ch.valid && !buf_valid_ff;
   assign in_colon     = (pos_ff == ColonRow);
   assign at_flush     = busy_ff && in_colon && (seg_ff == SEG_FLUSH);
   assign take         = adv && buf_valid_ff && (!busy_ff || at_flush);

   // Configuration writes
   always_comb begin
      mode_in    = mode_ff;
      seg_pix_in = seg_pix_ff;
      col_pix_in = col_pix_ff;
      first_in   = first_ff;
      map_in     = map_ff;
      strip_in   = strip_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_MODE_FLAGS:  mode_in    = csr_wdata[7:0];
            REG_SEG_PIXELS:  seg_pix_in = csr_wdata[7:0];
            REG_COL_PIXELS:  col_pix_in = csr_wdata[7:0];
            REG_FIRST_PIXEL: first_in   = csr_wdata[15:0];
            REG_SEGMENT_MAP: map_in     = csr_wdata[20:0];
            REG_STRIP_LEN:   strip_in   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Time sample decode: 12-hour fold, digit split, leading-zero blanking
   always_comb begin
      hour_fold = req_ch.hour_value;
      if (mode_ff[MODE_TWELVE]) begin
         if (req_ch.hour_value > 5'd12) begin
            hour_fold = req_ch.hour_value - 5'd12;
         end else if (req_ch.hour_value == '0) begin
            hour_fold = 5'd12;
         end
      end
      hour_dec   = split_decimal(6'(hour_fold));
      min_dec    = split_decimal(req_ch.minute_value);
      sec_dec    = split_decimal(req_ch.second_value);
      dig_val[0] = hour_dec[7:4];
      dig_val[1] = hour_dec[3:0];
      dig_val[2] = min_dec[7:4];
      dig_val[3] = min_dec[3:0];
      dig_val[4] = sec_dec[7:4];
      dig_val[5] = sec_dec[3:0];
      blank      = '0;
      blank[0]   = mode_ff[MODE_HIDE_HOUR] && (hour_dec[7:4] == '0);
      blank[2]   = mode_ff[MODE_HIDE_MIN] && (min_dec[7:4] == '0);
      for (int d = 0; d < MAX_DIGITS; d++) begin
         for (int s = 0; s < 7; s++) begin
            buf_dig_in[d][s] = mode_ff[MODE_ENABLE] && (d < 4 || six_en) &&
                               (blank[d] || !SEG_PATTERNS[dig_val[d]][6-s]);
         end
      end
      colon_dark = !mode_ff[MODE_SHOW_COLON] ||
                   (mode_ff[MODE_BLINK] && !req_ch.second_value[0]);
      buf_col_in[0] = mode_ff[MODE_ENABLE] && colon_dark;
      buf_col_in[1] = mode_ff[MODE_ENABLE] && colon_dark && six_en;
      buf_valid_in  = buf_valid_ff;
      if (take) begin
         buf_valid_in = 1'b0;
      end
      if (req_fire) begin
         buf_valid_in = 1'b1;
      end
   end

   // Segment map as seven 3-bit block positions
   always_comb begin
      for (int s = 0; s < 7; s++) begin
         map_blk[s] = map_ff[3*s +: 3];
      end
   end

   // Current slot: position and dark bit
   always_comb begin
      dpos = in_colon ? '0 : pos_ff[DigW-1:0];
      phys = mode_ff[MODE_RTL] ? (ndig - 3'd1 - 3'(dpos)) : 3'(dpos);
      blk  = map_blk[seg_ff];
      if (in_colon) begin
         slot_dark = ((seg_ff == SEG_COLON1) && col_dark_ff[0]) ||
                     ((seg_ff == SEG_COLON2) && col_dark_ff[1]);
         mult = (seg_ff == SEG_COLON2) ? COLON2_BLOCKS : COLON1_BLOCKS;
         cmul = (seg_ff == SEG_COLON2) ? 2'd1 : 2'd0;
      end else begin
         slot_dark = dig_dark_ff[dpos][seg_ff];
         mult = 6'(6'(phys) * 6'd7) + 6'(blk);
         cmul = phys[2:1];
      end
      seg_off = 14'(mult) * 14'(sp_eff);
      col_off = 10'(cmul) * 10'(cp_eff);
   end

   // Scanner step and candidate run stage
   always_comb begin
      busy_in     = busy_ff;
      pos_in      = pos_ff;
      seg_in      = seg_ff;
      dig_dark_in = dig_dark_ff;
      col_dark_in = col_dark_ff;
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      s1_start_in = s1_start_ff;
      s1_len_in   = s1_len_ff;
      if (adv) begin
         s1_valid_in = busy_ff && slot_dark;
         s1_flush_in = at_flush;
         s1_start_in = 18'(first_ff) + 18'(seg_off) + 18'(col_off);
         s1_len_in   = in_colon ? cp_eff : sp_eff;
         if (take) begin
            busy_in     = 1'b1;
            pos_in      = '0;
            seg_in      = '0;
            dig_dark_in = buf_dig_ff;
            col_dark_in = buf_col_ff;
         end else if (busy_ff) begin
            if (at_flush) begin
               busy_in = 1'b0;
            end else if (!in_colon && seg_ff == SEG_LAST) begin
               pos_in = pos_ff + 1'b1;
               seg_in = '0;
            end else begin
               seg_in = seg_ff + 3'd1;
            end
         end
      end
   end

   // Clip to the strip and hold one run back so the last one can be marked
   assign strip_ext = 18'(strip_ff);
   assign room      = strip_ext - s1_start_ff;
   assign run_ok    = s1_valid_ff && (s1_start_ff < strip_ext);
   assign clip_len  = (room < 18'(s1_len_ff)) ? room[7:0] : s1_len_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_run_in   = pend_run_ff;
      out_valid_in  = out_valid_ff;
      out_run_in    = out_run_ff;
      out_last_in   = out_last_ff;
      if (adv) begin
         out_run_in = pend_run_ff;
         if (run_ok) begin
            out_valid_in       = pend_valid_ff;
            out_last_in        = 1'b0;
            pend_valid_in      = 1'b1;
            pend_run_in.start  = s1_start_ff[15:0];
            pend_run_in.length = clip_len;
         end else if (s1_flush_ff) begin
            out_valid_in  = pend_valid_ff;
            out_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         seg_pix_ff    <= SEG_PIX_RST;
         col_pix_ff    <= COL_PIX_RST;
         first_ff      <= FIRST_RST;
         map_ff        <= MAP_RESET;
         strip_ff      <= STRIP_RST;
         buf_valid_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         pos_ff        <= '0;
         seg_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         s1_flush_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         seg_pix_ff    <= seg_pix_in;
         col_pix_ff    <= col_pix_in;
         first_ff      <= first_in;
         map_ff        <= map_in;
         strip_ff      <= strip_in;
         buf_valid_ff  <= buf_valid_in;
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
         seg_ff        <= seg_in;
         s1_valid_ff   <= s1_valid_in;
         s1_flush_ff   <= s1_flush_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         buf_dig_ff <= buf_dig_in;
         buf_col_ff <= buf_col_in;
      end
      dig_dark_ff <= dig_dark_in;
      col_dark_ff <= col_dark_in;
      s1_start_ff <= s1_start_in;
      s1_len_ff   <= s1_len_in;
      pend_run_ff <= pend_run_in;
      out_run_ff  <= out_run_in;
      out_last_ff <= out_last_in;
   end

   // Response outputs
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.run_start  = out_run_ff.start;
   assign rsp_ch.run_length = out_run_ff.length;
   assign rsp_ch.run_last   = out_last_ff;

   // Checks
   `include "seven_segment_clock_pixel_mask_assert.svh"

   `SSCPM_ASSERT_IMP(a_run_not_empty, clock, reset, out_valid_ff, out_run_ff.length != '0, "empty run presented")
   `SSCPM_ASSERT_IMP(a_idle_no_pending, clock, reset, !busy_ff && !s1_valid_ff && !s1_flush_ff, !pend_valid_ff, "run pending with scanner idle")
   `SSCPM_ASSERT_NEXT(a_flush_drains, clock, reset, adv && s1_flush_ff, !pend_valid_ff, "pending run kept past closing slot")
   `SSCPM_ASSERT_NEXT(a_take_starts_scan, clock, reset, take, busy_ff && pos_ff == '0 && seg_ff == '0, "scanner not restarted on new sample")

endmodule
